@@ src/gcrb_pkg.sv @@
// gcrb_pkg: shared constants for the tone curve remap block
// no dependencies; used by every module of the block

package gcrb_pkg;

    localparam int ENTRY_BITS      = 12;
    localparam int NODE_BITS       = 16;
    localparam int NODE_COUNT_BITS = 7;
    localparam int STRENGTH_BITS   = 11;
    localparam int STRENGTH_FRAC   = 10;

    localparam int ENTRY_FULL   = 2 ** ENTRY_BITS - 1;
    localparam int NODE_FULL    = 2 ** NODE_BITS - 1;
    localparam int STRENGTH_ONE = 2 ** STRENGTH_FRAC;

    localparam int MAX_NODES_DEFAULT = 64;
    localparam int QUEUE_DEPTH       = 4;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 11;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_NODE_COUNT     = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BLEND_STRENGTH = 1'b1;

    localparam logic [NODE_COUNT_BITS-1:0] NODE_COUNT_RESET = 7'd64;
    localparam logic [STRENGTH_BITS-1:0]   STRENGTH_RESET   = 11'd1024;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_REMAP = 1'b1;

endpackage

@@ src/gamma_curve_remap_blend_top.sv @@
// Tone curve remap top level: piecewise-linear curve over 12-bit gamma entries.
// Sustained rate is one item per cycle while the output is not stalled; a remap
// result passes the queue, then the back pipeline to the output register (queue
// pop with two-port node memory read, interpolation multiply, strength multiply,
// sum, round and clamp). Node loads give no result. The input stalls only while
// the four-entry queue between front and back is full, which happens when the
// output is held stalled. Config writes are always taken. MAX_NODES may be 2 to
// 256; nodes above index 63 cannot be loaded through the 6-bit index.
// uses gcrb_pkg, gcrb_front, gcrb_queue, gcrb_back

module gamma_curve_remap_blend_top #(
    parameter int MAX_NODES = gcrb_pkg::MAX_NODES_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_operation,
    input  logic [5:0]                          i_node_index,
    input  logic [gcrb_pkg::NODE_BITS-1:0]      i_node_value,
    input  logic [gcrb_pkg::ENTRY_BITS-1:0]     i_base_entry,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [gcrb_pkg::ENTRY_BITS-1:0]     o_mapped_entry,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gcrb_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [gcrb_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import gcrb_pkg::*;

    localparam int AW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
    localparam int IW = 1 + AW + NODE_BITS + ENTRY_BITS;

    logic [NODE_COUNT_BITS-1:0] r_node_count;
    logic [STRENGTH_BITS-1:0]   r_blend_strength;
    logic                       q_push, q_full, q_pop, q_empty;
    logic [IW-1:0]              q_in, q_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count     <= NODE_COUNT_RESET;
            r_blend_strength <= STRENGTH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_NODE_COUNT: begin
                    r_node_count <= i_cfg_data[NODE_COUNT_BITS-1:0];
                end
                CFG_BLEND_STRENGTH: begin
                    r_blend_strength <= i_cfg_data[STRENGTH_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    gcrb_front #(
        .MAX_NODES(MAX_NODES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_node_count (r_node_count),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_node_index (i_node_index),
        .i_node_value (i_node_value),
        .i_base_entry (i_base_entry),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_item     (q_in)
    );

    gcrb_queue #(
        .WIDTH(IW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    gcrb_back #(
        .MAX_NODES(MAX_NODES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_blend_strength (r_blend_strength),
        .i_q_empty        (q_empty),
        .i_q_item         (q_out),
        .o_q_pop          (q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_mapped_entry   (o_mapped_entry)
    );

endmodule

@@ src/gcrb_queue.sv @@
// gcrb_queue: small register fifo between the front and back parts
// uses gcrb_pkg

module gcrb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = gcrb_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(r_wr_ptr + 1'b1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(r_rd_ptr + 1'b1);
        end
        if (do_push && !do_pop) begin
            n_count = CW'(r_count + 1'b1);
        end else if (do_pop && !do_push) begin
            n_count = CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ src/gcrb_front.sv @@
// gcrb_front: accepts items, cleans node loads and places entries on the curve
// uses gcrb_pkg; feeds gcrb_queue

module gcrb_front #(
    parameter  int MAX_NODES = gcrb_pkg::MAX_NODES_DEFAULT,
    localparam int AW        = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1,
    localparam int IW        = 1 + AW + gcrb_pkg::NODE_BITS + gcrb_pkg::ENTRY_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [gcrb_pkg::NODE_COUNT_BITS-1:0] i_node_count,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_operation,
    input  logic [5:0]                           i_node_index,
    input  logic [gcrb_pkg::NODE_BITS-1:0]       i_node_value,
    input  logic [gcrb_pkg::ENTRY_BITS-1:0]      i_base_entry,
    input  logic                                 i_q_full,
    output logic                                 o_q_push,
    output logic [IW-1:0]                        o_q_item
);
    import gcrb_pkg::*;

    logic [NODE_BITS-1:0]    r_prev_node, n_prev_node;
    logic                    accept;
    logic                    load_ok;
    logic [AW:0]             n_act;
    logic [AW-1:0]           nm1;
    logic [NODE_BITS-1:0]    clean_val;
    logic [ENTRY_BITS+AW-1:0] scaled;
    logic [AW-1:0]           q0;
    logic [ENTRY_BITS:0]     r0;
    logic                    corr;
    logic [AW-1:0]           lo;
    logic [ENTRY_BITS-1:0]   rem;
    logic [AW-1:0]           addr;
    logic [NODE_BITS-1:0]    val;

    always_comb begin
        if (i_node_count < NODE_COUNT_BITS'(2)) begin
            n_act = (AW+1)'(2);
        end else if (32'(i_node_count) > MAX_NODES) begin
            n_act = (AW+1)'(MAX_NODES);
        end else begin
            n_act = (AW+1)'(i_node_count);
        end
        nm1 = AW'(n_act - 1'b1);
    end

    // node cleaning
    always_comb begin
        if (i_node_index == '0) begin
            clean_val = '0;
        end else if (32'(i_node_index) == 32'(nm1)) begin
            clean_val = NODE_BITS'(NODE_FULL);
        end else if (i_node_value < r_prev_node) begin
            clean_val = r_prev_node;
        end else begin
            clean_val = i_node_value;
        end
    end

    // position on the curve, divide by the full entry scale
    always_comb begin
        scaled = (ENTRY_BITS+AW)'(i_base_entry) * (ENTRY_BITS+AW)'(nm1);
        q0     = scaled[ENTRY_BITS+AW-1:ENTRY_BITS];
        r0     = {1'b0, scaled[ENTRY_BITS-1:0]} + (ENTRY_BITS+1)'(q0);
        corr   = (r0 >= (ENTRY_BITS+1)'(ENTRY_FULL));
        if (corr) begin
            rem = ENTRY_BITS'(r0 - (ENTRY_BITS+1)'(ENTRY_FULL));
        end else begin
            rem = ENTRY_BITS'(r0);
        end
        lo = AW'(q0 + AW'(corr));
        if (lo >= nm1) begin
            lo  = AW'(nm1 - 1'b1);
            rem = ENTRY_BITS'(ENTRY_FULL);
        end
    end

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign load_ok    = (32'(i_node_index) < MAX_NODES);

    always_comb begin
        if (i_operation == OP_REMAP) begin
            addr = lo;
            val  = NODE_BITS'(rem);
        end else begin
            addr = AW'(i_node_index);
            val  = clean_val;
        end
        o_q_item = {i_operation, addr, val, i_base_entry};
        o_q_push = accept && ((i_operation == OP_REMAP) || load_ok);
        n_prev_node = r_prev_node;
        if (accept && (i_operation == OP_LOAD) && load_ok) begin
            n_prev_node = clean_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_node <= '0;
        end else begin
            r_prev_node <= n_prev_node;
        end
    end

endmodule

@@ src/gcrb_back.sv @@
// gcrb_back: node memory, interpolation, blend, rounding and output register
// uses gcrb_pkg; drains gcrb_queue

module gcrb_back #(
    parameter  int MAX_NODES = gcrb_pkg::MAX_NODES_DEFAULT,
    localparam int AW        = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1,
    localparam int IW        = 1 + AW + gcrb_pkg::NODE_BITS + gcrb_pkg::ENTRY_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [gcrb_pkg::STRENGTH_BITS-1:0] i_blend_strength,
    input  logic                               i_q_empty,
    input  logic [IW-1:0]                      i_q_item,
    output logic                               o_q_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [gcrb_pkg::ENTRY_BITS-1:0]    o_mapped_entry
);
    import gcrb_pkg::*;

    localparam int M_BITS = NODE_BITS + ENTRY_BITS;
    localparam int D_BITS = M_BITS + 1;
    localparam int P_BITS = STRENGTH_BITS + 1 + D_BITS;
    localparam int T_BITS = P_BITS + 1;
    localparam longint DEN = longint'(STRENGTH_ONE) * longint'(NODE_FULL);
    localparam logic signed [T_BITS-1:0] HALF_DEN  = T_BITS'(DEN / 2);
    localparam logic signed [T_BITS-1:0] SAT_LIMIT = T_BITS'(DEN * (ENTRY_FULL + 1));

    logic                  advance;
    logic                  q_op;
    logic [AW-1:0]         q_addr;
    logic [NODE_BITS-1:0]  q_val;
    logic [ENTRY_BITS-1:0] q_base;

    logic [NODE_BITS-1:0]  r_mem [MAX_NODES];

    logic                  r_s1_valid;
    logic [NODE_BITS-1:0]  r_s1_lo, r_s1_hi;
    logic [ENTRY_BITS-1:0] r_s1_rem, r_s1_base;

    logic                  r_s2_valid;
    logic [M_BITS-1:0]     r_s2_m, r_s2_bm;

    logic                    r_s3_valid;
    logic signed [P_BITS-1:0] r_s3_p;
    logic [M_BITS-1:0]       r_s3_bm;

    logic                    r_s4_valid;
    logic signed [T_BITS-1:0] r_s4_t;

    logic                  r_out_valid;
    logic [ENTRY_BITS-1:0] r_out_entry;

    logic signed [NODE_BITS:0]         diff;
    logic signed [NODE_BITS+ENTRY_BITS+1:0] prod;
    logic [M_BITS-1:0]                 lo_scaled;
    logic signed [M_BITS+1:0]          m_sum;
    logic [M_BITS-1:0]                 bm;
    logic [STRENGTH_BITS-1:0]          strength;
    logic signed [D_BITS-1:0]          d;
    logic signed [P_BITS-1:0]          p;
    logic signed [T_BITS-1:0]          bm_ext, t_sum;
    logic [M_BITS-1:0]                 u;
    logic [ENTRY_BITS-1:0]             q0, q;
    logic [NODE_BITS:0]                r0;
    logic [ENTRY_BITS-1:0]             n_out_entry;

    assign advance = !r_out_valid || !i_out_stall;
    assign o_q_pop = advance && !i_q_empty;
    assign {q_op, q_addr, q_val, q_base} = i_q_item;

    // node memory, loads write and remaps read two neighbors
    always_ff @(posedge i_clk) begin
        if (o_q_pop && (q_op == OP_LOAD)) begin
            r_mem[q_addr] <= q_val;
        end
        if (advance) begin
            r_s1_lo <= r_mem[q_addr];
            r_s1_hi <= r_mem[AW'(q_addr + 1'b1)];
        end
    end

    always_comb begin
        diff      = $signed({1'b0, r_s1_hi}) - $signed({1'b0, r_s1_lo});
        prod      = diff * $signed({1'b0, r_s1_rem});
        lo_scaled = {r_s1_lo, {ENTRY_BITS{1'b0}}} - M_BITS'(r_s1_lo);
        m_sum     = $signed({2'b00, lo_scaled}) + prod;
        bm        = {r_s1_base, {NODE_BITS{1'b0}}} - M_BITS'(r_s1_base);
    end

    always_comb begin
        if (i_blend_strength > STRENGTH_BITS'(STRENGTH_ONE)) begin
            strength = STRENGTH_BITS'(STRENGTH_ONE);
        end else begin
            strength = i_blend_strength;
        end
        d = $signed({1'b0, r_s2_m}) - $signed({1'b0, r_s2_bm});
        p = $signed({1'b0, strength}) * d;
    end

    always_comb begin
        bm_ext = $signed({{(T_BITS - M_BITS - STRENGTH_FRAC){1'b0}}, r_s3_bm,
                          {STRENGTH_FRAC{1'b0}}});
        t_sum  = bm_ext + T_BITS'(r_s3_p) + HALF_DEN;
    end

    // round and clamp, divide by full node scale
    always_comb begin
        u  = r_s4_t[STRENGTH_FRAC+M_BITS-1:STRENGTH_FRAC];
        q0 = u[M_BITS-1:NODE_BITS];
        r0 = {1'b0, u[NODE_BITS-1:0]} + (NODE_BITS+1)'(q0);
        q  = ENTRY_BITS'(q0 + ENTRY_BITS'(r0 >= (NODE_BITS+1)'(NODE_FULL)));
        if (r_s4_t <= HALF_DEN) begin
            n_out_entry = '0;
        end else if (r_s4_t >= SAT_LIMIT) begin
            n_out_entry = ENTRY_BITS'(ENTRY_FULL);
        end else begin
            n_out_entry = q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= o_q_pop && (q_op == OP_REMAP);
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_out_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_rem    <= q_val[ENTRY_BITS-1:0];
            r_s1_base   <= q_base;
            r_s2_m      <= M_BITS'(m_sum);
            r_s2_bm     <= bm;
            r_s3_p      <= p;
            r_s3_bm     <= r_s2_bm;
            r_s4_t      <= t_sum;
            r_out_entry <= n_out_entry;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_mapped_entry = r_out_entry;

endmodule
